FILE: design/lba_to_chs_translate_assert.svh
// assertion macros for the translator rtl
`ifndef LBA_TO_CHS_TRANSLATE_ASSERT_SVH
`define LBA_TO_CHS_TRANSLATE_ASSERT_SVH

// condition implies consequence in the same cycle
`define LCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lct assertion failed");

// condition implies consequence in the next cycle
`define LCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lct assertion failed");

`endif

FILE: design/lct_pkg.sv
// shared types, constants and divider step functions for the lba to chs translator
package lct_pkg;

  localparam int LbaBits  = 32;
  localparam int CylBits  = 24;
  localparam int HeadBits = 8;
  localparam int SptBits  = 6;
  localparam int RemBits  = HeadBits + SptBits;
  localparam int CfgIdxBits  = 8;
  localparam int CfgDataBits = 8;

  localparam logic [LbaBits-1:0]  LbaLimit      = 32'd16450560;
  localparam logic [CylBits-1:0]  ClampCylinder = 24'd1022;
  localparam logic [HeadBits-1:0] ClampHead     = 8'd254;
  localparam logic [SptBits-1:0]  ClampSector   = 6'd63;
  localparam logic [HeadBits-1:0] HeadsReset    = 8'd255;
  localparam logic [SptBits-1:0]  SptReset      = 6'd63;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgHeadsIdx = 8'd0;
  localparam logic [CfgIdxBits-1:0] CfgSptIdx   = 8'd1;

  // special-case flags that ride along with each transaction
  typedef struct packed {
    logic clamped;
    logic err;
  } lct_ctrl_t;

  // cylinder divider stage: partial remainder and shifting dividend/quotient word
  typedef struct packed {
    lct_ctrl_t           ctrl;
    logic [RemBits-1:0]  div;
    logic [SptBits-1:0]  spt;
    logic [RemBits-1:0]  rem;
    logic [CylBits-1:0]  work;
  } lct_cyl_t;

  // head divider stage
  typedef struct packed {
    lct_ctrl_t           ctrl;
    logic [CylBits-1:0]  cyl;
    logic [SptBits-1:0]  spt;
    logic [SptBits-1:0]  rem;
    logic [HeadBits-1:0] work;
  } lct_head_t;

  // finished result
  typedef struct packed {
    logic [CylBits-1:0]  cylinder;
    logic [HeadBits-1:0] head;
    logic [SptBits-1:0]  sector;
    logic                clamped;
    logic                err;
  } lct_res_t;

  // one restoring division step for the cylinder quotient
  function automatic lct_cyl_t cyl_step(lct_cyl_t s);
    logic [RemBits:0] trial;
    logic             ge;
    lct_cyl_t         r;
    trial = {s.rem, s.work[CylBits-1]};
    ge = (trial >= {1'b0, s.div});
    r = s;
    r.rem = ge ? RemBits'(trial - {1'b0, s.div}) : trial[RemBits-1:0];
    r.work = {s.work[CylBits-2:0], ge};
    return r;
  endfunction

  // remainder top bits are already below spt since remainder < heads * spt
  function automatic lct_head_t head_init(lct_cyl_t s);
    lct_head_t r;
    r.ctrl = s.ctrl;
    r.cyl  = s.work;
    r.spt  = s.spt;
    r.rem  = s.rem[RemBits-1:HeadBits];
    r.work = s.rem[HeadBits-1:0];
    return r;
  endfunction

  // one restoring division step for the head quotient
  function automatic lct_head_t head_step(lct_head_t s);
    logic [SptBits:0] trial;
    logic             ge;
    lct_head_t        r;
    trial = {s.rem, s.work[HeadBits-1]};
    ge = (trial >= {1'b0, s.spt});
    r = s;
    r.rem = ge ? SptBits'(trial - {1'b0, s.spt}) : trial[SptBits-1:0];
    r.work = {s.work[HeadBits-2:0], ge};
    return r;
  endfunction

endpackage

FILE: design/lct_front.sv
// input stage: classify lba, form zero-based index and sectors per cylinder
module lct_front import lct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [LbaBits-1:0]  lba_i,
  input  logic [HeadBits-1:0] heads_i,
  input  logic [SptBits-1:0]  spt_i,
  output logic                valid_o,
  output lct_cyl_t            stage_o
);

  logic          valid_q;
  lct_cyl_t      stage_d, stage_q;
  logic [LbaBits-1:0] idx;

  // decode special cases and prime the cylinder divider
  always_comb begin
    idx = lba_i - LbaBits'(1);
    stage_d.ctrl.clamped = (lba_i > LbaLimit);
    stage_d.ctrl.err = !stage_d.ctrl.clamped &&
                       ((lba_i == '0) || (heads_i == '0) || (spt_i == '0));
    stage_d.div  = {{SptBits{1'b0}}, heads_i} * {{HeadBits{1'b0}}, spt_i};
    stage_d.spt  = spt_i;
    stage_d.rem  = '0;
    stage_d.work = idx[CylBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

FILE: design/lct_cyl_div.sv
// pipelined restoring divider, one cylinder quotient bit per stage
module lct_cyl_div import lct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  lct_cyl_t stage_i,
  output logic     valid_o,
  output lct_cyl_t stage_o
);

  logic [CylBits-1:0] valid_q;
  lct_cyl_t           stage_q [CylBits];

  // valid bits shift along with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[CylBits-2:0], valid_i};
    end
  end

  // division stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= cyl_step(stage_i);
    end
  end

  for (genvar k = 1; k < CylBits; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= cyl_step(stage_q[k-1]);
      end
    end
  end

  assign valid_o = valid_q[CylBits-1];
  assign stage_o = stage_q[CylBits-1];

endmodule

FILE: design/lct_head_div.sv
// pipelined restoring divider, remainder by sectors per track, one head bit per stage
module lct_head_div import lct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  lct_cyl_t  stage_i,
  output logic      valid_o,
  output lct_head_t stage_o
);

  logic [HeadBits-1:0] valid_q;
  lct_head_t           stage_q [HeadBits];

  // valid bits shift along with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[HeadBits-2:0], valid_i};
    end
  end

  // first stage takes the cylinder remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= head_step(head_init(stage_i));
    end
  end

  for (genvar k = 1; k < HeadBits; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= head_step(stage_q[k-1]);
      end
    end
  end

  assign valid_o = valid_q[HeadBits-1];
  assign stage_o = stage_q[HeadBits-1];

endmodule

FILE: design/lba_to_chs_translate.sv
// throughput: one transaction per cycle while the skid register is empty, set by the 24 + 8 stage restoring dividers
// a stalled output fills a one-entry skid register, then the input stalls
// reset clears all valid bits and loads geometry 255 heads, 63 sectors per track
// top level of the lba to chs translator
module lba_to_chs_translate import lct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [LbaBits-1:0]     lba_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CylBits-1:0]     cylinder_o,
  output logic [HeadBits-1:0]    head_o,
  output logic [SptBits-1:0]     sector_o,
  output logic [7:0]             packed_cylinder_o,
  output logic [7:0]             packed_head_o,
  output logic [7:0]             packed_sector_o,
  output logic                   clamped_o,
  output logic                   error_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

`include "lba_to_chs_translate_assert.svh"

  logic [HeadBits-1:0] heads_q;
  logic [SptBits-1:0]  spt_q;
  logic                en;
  logic                front_valid, cyl_valid, head_valid;
  lct_cyl_t            front_stage, cyl_stage;
  lct_head_t           head_stage;
  lct_res_t            res;
  lct_res_t            out_q, skid_q;
  logic                out_valid_q, skid_full_q;
  logic                out_fire;

  // geometry registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heads_q <= HeadsReset;
      spt_q   <= SptReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgHeadsIdx) begin
        heads_q <= cfg_data_i[HeadBits-1:0];
      end else if (cfg_index_i == CfgSptIdx) begin
        spt_q <= cfg_data_i[SptBits-1:0];
      end
    end
  end

  // whole pipeline advances unless the skid register is holding a result
  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  lct_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .lba_i   (lba_i),
    .heads_i (heads_q),
    .spt_i   (spt_q),
    .valid_o (front_valid),
    .stage_o (front_stage)
  );

  lct_cyl_div u_cyl_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .stage_i (front_stage),
    .valid_o (cyl_valid),
    .stage_o (cyl_stage)
  );

  lct_head_div u_head_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cyl_valid),
    .stage_i (cyl_stage),
    .valid_o (head_valid),
    .stage_o (head_stage)
  );

  // final selection between computed, clamped and error results
  always_comb begin
    res.clamped = head_stage.ctrl.clamped;
    res.err     = head_stage.ctrl.err;
    if (head_stage.ctrl.clamped) begin
      res.cylinder = ClampCylinder;
      res.head     = ClampHead;
      res.sector   = ClampSector;
    end else if (head_stage.ctrl.err) begin
      res.cylinder = '0;
      res.head     = '0;
      res.sector   = '0;
    end else begin
      res.cylinder = head_stage.cyl;
      res.head     = head_stage.work;
      res.sector   = head_stage.rem + SptBits'(1);
    end
  end

  // output register with one-entry skid
  assign out_fire = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (out_fire) begin
        skid_full_q <= 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_q <= head_valid;
    end else if (head_valid) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_fire) begin
      out_q <= res;
    end else if (head_valid) begin
      skid_q <= res;
    end
  end

  // result ports and mbr byte packing
  assign out_valid_o       = out_valid_q;
  assign cylinder_o        = out_q.cylinder;
  assign head_o            = out_q.head;
  assign sector_o          = out_q.sector;
  assign packed_cylinder_o = out_q.cylinder[7:0];
  assign packed_head_o     = out_q.head;
  assign packed_sector_o   = {out_q.cylinder[9:8], out_q.sector};
  assign clamped_o         = out_q.clamped;
  assign error_o           = out_q.err;

  // checks
  `LCT_ASSERT_IMPL(a_skid_needs_out, clk_i, rst_ni, skid_full_q, out_valid_q)
  `LCT_ASSERT_IMPL(a_flags_exclusive, clk_i, rst_ni, out_valid_o, !(clamped_o && error_o))
  `LCT_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_valid_o && error_o,
                   (cylinder_o == '0) && (packed_sector_o == '0) && (head_o == '0))
  `LCT_ASSERT_IMPL(a_sector_nonzero, clk_i, rst_ni, out_valid_o && !error_o, sector_o != '0)
  `LCT_ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, skid_full_q && !out_stall_i, !skid_full_q)

endmodule

FILE: tb/sv/lba_to_chs_translate_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the lba to chs translator with random idling and back-pressure
module lba_to_chs_translate_test;
  import lct_pkg::*;

  localparam int ClkHalf       = 10;
  localparam int LatencyCycles = 34;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;
  localparam int MaxReports    = 10;
  localparam logic [CfgIdxBits-1:0] CfgFirstUnusedIdx = CfgSptIdx + 1'b1;
  localparam logic [LbaBits-1:0]    DefaultPerCyl     = 32'(HeadsReset) * 32'(SptReset);

  // one translated address as it leaves the block
  typedef struct packed {
    logic [CylBits-1:0]  cylinder;
    logic [HeadBits-1:0] head;
    logic [SptBits-1:0]  sector;
    logic [7:0]          pcyl;
    logic [7:0]          phead;
    logic [7:0]          psec;
    logic                clamped;
    logic                err;
  } chs_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic [LbaBits-1:0]     lba_i       = '0;
  logic                   out_stall_i = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i  = '0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic [CylBits-1:0]     cylinder_o;
  logic [HeadBits-1:0]    head_o;
  logic [SptBits-1:0]     sector_o;
  logic [7:0]             packed_cylinder_o;
  logic [7:0]             packed_head_o;
  logic [7:0]             packed_sector_o;
  logic                   clamped_o;
  logic                   error_o;
  logic                   cfg_ready_o;

  // geometry as the block should currently hold it
  logic [HeadBits-1:0] geo_heads = HeadsReset;
  logic [SptBits-1:0]  geo_spt   = SptReset;

  logic [LbaBits-1:0] pending_lba[$];
  chs_t               expected_chs[$];
  logic [LbaBits-1:0] expected_lba[$];

  int in_idle_pct    = 0;
  int out_idle_pct   = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int hold_req       = 0;
  int hold_ack       = 0;
  int quiet_cycles   = 0;
  int n_queued       = 0;
  int n_lba_accepted = 0;
  int n_checked      = 0;
  int n_clamped_seen = 0;
  int n_error_seen   = 0;
  int n_cfg_writes   = 0;
  int n_errors       = 0;

  lba_to_chs_translate uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .lba_i            (lba_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cylinder_o       (cylinder_o),
    .head_o           (head_o),
    .sector_o         (sector_o),
    .packed_cylinder_o(packed_cylinder_o),
    .packed_head_o    (packed_head_o),
    .packed_sector_o  (packed_sector_o),
    .clamped_o        (clamped_o),
    .error_o          (error_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  // expected chs triple and mbr bytes for one sector number under the current geometry
  function automatic chs_t translate_chs(logic [LbaBits-1:0] lba);
    logic [31:0] per_cyl;
    logic [31:0] idx;
    logic [31:0] rem;
    chs_t        r;
    r = '0;
    if (lba > LbaLimit) begin
      r.cylinder = ClampCylinder;
      r.head     = ClampHead;
      r.sector   = ClampSector;
      r.clamped  = 1'b1;
    end else if (lba == '0 || geo_heads == '0 || geo_spt == '0) begin
      r.err = 1'b1;
    end else begin
      per_cyl    = 32'(geo_heads) * 32'(geo_spt);
      idx        = lba - 1;
      rem        = idx % per_cyl;
      r.cylinder = CylBits'(idx / per_cyl);
      r.head     = HeadBits'(rem / 32'(geo_spt));
      r.sector   = SptBits'(rem % 32'(geo_spt) + 1);
    end
    if (!r.err) begin
      r.pcyl  = r.cylinder[7:0];
      r.phead = r.head;
      r.psec  = {r.cylinder[9:8], r.sector};
    end
    return r;
  endfunction

  // idle burst length: mostly short, now and then long
  function automatic int idle_len(int pct);
    int r;
    if ($urandom_range(0, 99) >= pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sector numbers spread over small values, cylinder boundaries, the limit and the full range
  function automatic logic [LbaBits-1:0] random_lba();
    logic [31:0] per_cyl;
    logic [31:0] base;
    int          sel;
    per_cyl = 32'(geo_heads) * 32'(geo_spt);
    if (per_cyl == 0) per_cyl = 1;
    sel = $urandom_range(0, 99);
    if (sel < 15) return $urandom();
    if (sel < 25) return $urandom_range(0, 64);
    if (sel < 35) return LbaLimit - 3 + $urandom_range(0, 6);
    if (sel < 65) begin
      base = per_cyl * $urandom_range(0, LbaLimit / per_cyl);
      return base + $urandom_range(0, 2);
    end
    return $urandom_range(1, LbaLimit);
  endfunction

  // input driver: predicts on each accepted transaction, holds payload while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      lba_i      <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_chs.push_back(translate_chs(lba_i));
        expected_lba.push_back(lba_i);
        n_lba_accepted <= n_lba_accepted + 1;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_lba.size() != 0) begin
          in_valid_i <= 1'b1;
          lba_i      <= pending_lba.pop_front();
          gap_left   <= idle_len(in_idle_pct);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output stall: random bursts, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      hold_ack    <= 0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_ack != hold_req) begin
      hold_ack    <= hold_req;
      stall_left  <= HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin : pick_stall
      int len;
      len = idle_len(out_idle_pct);
      out_stall_i <= (len > 0);
      stall_left  <= (len > 0) ? len - 1 : 0;
    end
  end

  // output monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin : check_result
      chs_t               want;
      chs_t               got;
      logic [LbaBits-1:0] lba;
      got.cylinder = cylinder_o;
      got.head     = head_o;
      got.sector   = sector_o;
      got.pcyl     = packed_cylinder_o;
      got.phead    = packed_head_o;
      got.psec     = packed_sector_o;
      got.clamped  = clamped_o;
      got.err      = error_o;
      if (expected_chs.size() == 0) begin
        if (n_errors < MaxReports) $display("unexpected result: cyl %0d head %0d sec %0d",
                                            got.cylinder, got.head, got.sector);
        n_errors = n_errors + 1;
      end else begin
        want = expected_chs.pop_front();
        lba  = expected_lba.pop_front();
        n_checked <= n_checked + 1;
        if (got.clamped) n_clamped_seen <= n_clamped_seen + 1;
        if (got.err) n_error_seen <= n_error_seen + 1;
        if (got.cylinder !== want.cylinder || got.head !== want.head ||
            got.sector !== want.sector || got.pcyl !== want.pcyl ||
            got.phead !== want.phead || got.psec !== want.psec ||
            got.clamped !== want.clamped || got.err !== want.err) begin
          if (n_errors < MaxReports) begin
            $display("mismatch lba %0d: expected chs %0d/%0d/%0d mbr %h %h %h clamp %b err %b",
                     lba, want.cylinder, want.head, want.sector, want.pcyl, want.phead,
                     want.psec, want.clamped, want.err);
            $display("                got chs %0d/%0d/%0d mbr %h %h %h clamp %b err %b",
                     got.cylinder, got.head, got.sector, got.pcyl, got.phead, got.psec,
                     got.clamped, got.err);
          end
          n_errors = n_errors + 1;
        end
      end
    end
  end

  // geometry tracking on accepted register writes, unknown indexes are dropped
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo_heads <= HeadsReset;
      geo_spt   <= SptReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      n_cfg_writes <= n_cfg_writes + 1;
      if (cfg_index_i == CfgHeadsIdx) geo_heads <= cfg_data_i;
      else if (cfg_index_i == CfgSptIdx) geo_spt <= cfg_data_i[SptBits-1:0];
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one register write over the configuration channel
  task automatic write_cfg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // queue random sector numbers and wait until every result has been checked
  task automatic run_phase(int n_items, int in_pct, int out_pct, bit hold);
    @(posedge clk_i);
    in_idle_pct  <= in_pct;
    out_idle_pct <= out_pct;
    if (hold) hold_req <= hold_req + 1;
    for (int i = 0; i < n_items; i++) begin
      pending_lba.push_back(random_lba());
      n_queued++;
    end
    do @(posedge clk_i); while (n_lba_accepted != n_queued || n_checked != n_lba_accepted);
  endtask

  // stimulus sequence
  initial begin : main
    logic [LbaBits-1:0] directed_lba[$];
    directed_lba = '{'0, 32'd1, 32'd2, 32'd63, 32'd64, DefaultPerCyl, DefaultPerCyl + 1,
                     DefaultPerCyl * 256 + 1, DefaultPerCyl * 768 + 1, LbaLimit - 1,
                     LbaLimit, LbaLimit + 1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_FFFF};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: directed corners first
    foreach (directed_lba[i]) begin
      pending_lba.push_back(directed_lba[i]);
      n_queued++;
    end
    run_phase(90, 30, 30, 1'b0);

    // smallest geometry, largest cylinder numbers
    write_cfg(CfgHeadsIdx, 8'd1);
    write_cfg(CfgSptIdx, 8'd1);
    run_phase(120, 30, 30, 1'b0);

    // largest geometry, upper data bits masked off, no idling at all
    write_cfg(CfgHeadsIdx, 8'hFF);
    write_cfg(CfgSptIdx, 8'hFF);
    write_cfg(8'hFF, 8'h00);
    run_phase(120, 0, 0, 1'b0);

    // zero heads
    write_cfg(CfgHeadsIdx, 8'd0);
    write_cfg(CfgSptIdx, 8'd17);
    run_phase(60, 30, 30, 1'b0);

    // zero sectors per track through the masked data bits
    write_cfg(CfgHeadsIdx, 8'd16);
    write_cfg(CfgSptIdx, 8'h40);
    run_phase(60, 50, 20, 1'b0);

    // back-pressure: receiver holds off while the sender keeps offering
    write_cfg(CfgHeadsIdx, HeadsReset);
    write_cfg(CfgSptIdx, 8'(SptReset));
    run_phase(150, 0, 10, 1'b1);

    // random geometries
    repeat (3) begin
      write_cfg(CfgHeadsIdx, 8'($urandom_range(0, 255)));
      write_cfg(CfgSptIdx, 8'($urandom_range(0, 255)));
      write_cfg(CfgIdxBits'(CfgFirstUnusedIdx + $urandom_range(0, 253)),
                8'($urandom_range(0, 255)));
      run_phase(150, 30, 40, 1'b0);
    end

    repeat (LatencyCycles + 4) @(posedge clk_i);
    if (expected_chs.size() != 0) begin
      $display("%0d translations never came out", expected_chs.size());
      n_errors = n_errors + expected_chs.size();
    end
    $display("checked %0d translations: %0d clamped, %0d flagged as zero lba or zero geometry",
             n_checked, n_clamped_seen, n_error_seen);
    $display("geometry changed over %0d register writes, one long output hold-off",
             n_cfg_writes);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
